// ----- rtl/sstf_pkg.sv -----
// Shared types and constants for the shortest-seek-first scheduler.
// Used by sstf_cell and sstf_seek_scheduler; depends on nothing.
`default_nettype none
package sstf_pkg;

	localparam int CYL_W = 16;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int TOT_W = 22;

	localparam int DEF_MAX_REQUESTS  = 64;
	localparam int DEF_CYLINDER_BITS = 16;

	typedef struct packed {
		logic             found;
		logic [CYL_W-1:0] gap;
		logic [IDX_W-1:0] idx;
		logic [CYL_W-1:0] cyl;
	} cand_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [CYL_W-1:0] wr_cyl;
		logic             clear;
		logic             mark_en;
		logic [IDX_W-1:0] mark_idx;
		logic [CYL_W-1:0] head;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_SEARCH
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/sstf_cell.sv -----
// One request slot of the scheduler chain: holds a cylinder and its flags,
// and passes the best candidate so far to its neighbor. Uses sstf_pkg.
`default_nettype none
module sstf_cell
	import sstf_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire cand_t      cand_i,
	output cand_t           cand_o
);

	logic [CYL_W-1:0] cyl_q;
	logic             valid_q;
	logic             served_q;
	cand_t            cand_q;

	logic [CYL_W-1:0] gap;
	logic             take;

	always_comb begin
		gap  = (cyl_q >= ctrl.head) ? (cyl_q - ctrl.head) : (ctrl.head - cyl_q);
		take = valid_q && !served_q && (!cand_i.found || (gap <= cand_i.gap));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			served_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q  <= 1'b0;
			served_q <= 1'b0;
		end else begin
			if (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(IDX))) begin
				valid_q <= 1'b1;
			end
			if (ctrl.mark_en && (ctrl.mark_idx == IDX_W'(IDX))) begin
				served_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(IDX))) begin
			cyl_q <= ctrl.wr_cyl;
		end
		if (take) begin
			cand_q.found <= 1'b1;
			cand_q.gap   <= gap;
			cand_q.idx   <= IDX_W'(IDX);
			cand_q.cyl   <= cyl_q;
		end else begin
			cand_q <= cand_i;
		end
	end

	assign cand_o = cand_q;

endmodule
`default_nettype wire

// ----- rtl/sstf_seek_scheduler.sv -----
// Top level of the shortest-seek-first scheduler: request loading, pick
// sequencing and the result register. Uses sstf_pkg and sstf_cell.
//
// Requests enter one per cycle, each into its own cell of a chain of
// MAX_REQUESTS cells; the request with tlast set starts scheduling from the
// configured start cylinder. Each pick is a sweep of a candidate through the
// whole chain, one cell per cycle, and a batch yields one result per stored
// request. Ties in distance go to the latest-loaded request. No input is
// taken while a batch is being scheduled; a waiting result holds back the
// capture of the next pick until it is accepted, and loading of the next
// batch starts as soon as the final result is registered. Requests past
// capacity are dropped and reported in tuser on every result of the batch.
`default_nettype none
module sstf_seek_scheduler
	import sstf_pkg::*;
#(
	parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
	parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,   // start_cylinder
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,       // cylinder
	input  wire logic        s_tlast,       // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,       // served_cylinder, served_index,
	                                        // seek_distance, total_distance, zero fill
	output logic             m_tlast,       // end_of_order
	output logic             m_tuser        // overflow
);

	localparam int CW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
	localparam logic [CYL_W-1:0] CYL_MASK = CYL_W'((17'(1) << CW) - 17'(1));
	localparam logic [CNT_W-1:0] NREQ = CNT_W'(MAX_REQUESTS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] remain_q;
	logic [CNT_W-1:0] sweep_q;
	logic             ovf_q;
	logic [CYL_W-1:0] head_q;
	logic [TOT_W-1:0] total_q;
	logic [CYL_W-1:0] start_q;

	logic             out_valid_q;
	logic [CYL_W-1:0] out_cyl_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [CYL_W-1:0] out_dist_q;
	logic [TOT_W-1:0] out_tot_q;
	logic             out_ovf_q;
	logic             out_end_q;

	cell_ctrl_t       ctrl;
	cand_t            chain [MAX_REQUESTS+1];
	cand_t            pick;

	logic             in_fire;
	logic             store_ok;
	logic             sweep_done;
	logic             capture;
	logic             last_pick;
	logic [TOT_W-1:0] total_next;

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
		sstf_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.cand_i(chain[i]),
			.cand_o(chain[i+1])
		);
	end

	assign pick       = chain[MAX_REQUESTS];
	assign in_fire    = s_tvalid && s_tready;
	assign store_ok   = count_q < NREQ;
	assign sweep_done = (state_q == ST_SEARCH) && (sweep_q == NREQ);
	assign capture    = sweep_done && (!out_valid_q || m_tready);
	assign last_pick  = remain_q == CNT_W'(1);
	assign total_next = total_q + TOT_W'(pick.gap);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire && s_tlast) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (capture && last_pick) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_LOAD);
		ctrl.wr_en    = in_fire && store_ok;
		ctrl.wr_idx   = count_q[IDX_W-1:0];
		ctrl.wr_cyl   = s_tdata & CYL_MASK;
		ctrl.clear    = capture && last_pick;
		ctrl.mark_en  = capture;
		ctrl.mark_idx = pick.idx;
		ctrl.head     = head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			remain_q    <= '0;
			sweep_q     <= '0;
			ovf_q       <= 1'b0;
			head_q      <= '0;
			total_q     <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				start_q <= cfg_wr_data;
			end
			if (in_fire) begin
				if (store_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (s_tlast) begin
					remain_q <= store_ok ? (count_q + CNT_W'(1)) : count_q;
					head_q   <= start_q & CYL_MASK;
					total_q  <= '0;
					sweep_q  <= '0;
				end
			end
			if (state_q == ST_SEARCH) begin
				if (capture) begin
					sweep_q <= '0;
				end else if (!sweep_done) begin
					sweep_q <= sweep_q + CNT_W'(1);
				end
			end
			if (capture) begin
				head_q      <= pick.cyl;
				total_q     <= total_next;
				remain_q    <= remain_q - CNT_W'(1);
				out_valid_q <= 1'b1;
				if (last_pick) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_cyl_q  <= pick.cyl;
			out_idx_q  <= pick.idx;
			out_dist_q <= pick.gap;
			out_tot_q  <= total_next;
			out_ovf_q  <= ovf_q;
			out_end_q  <= last_pick;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_tot_q, out_dist_q, out_idx_q, out_cyl_q};
	assign m_tlast  = out_end_q;
	assign m_tuser  = out_ovf_q;

endmodule
`default_nettype wire
